@@ rtl/core/skq_pkg.sv @@
`timescale 1ns / 1ps

package skq_pkg;

	// Field widths fixed by the stream format
	localparam int unsigned KeyW   = 32;
	localparam int unsigned TagW   = 32;
	localparam int unsigned ReqW   = 2;
	localparam int unsigned CountW = 5;
	localparam int unsigned FlagW  = 3;
	localparam int unsigned InW    = 64;
	localparam int unsigned OutW   = 72;

	// Request codes
	typedef enum logic [ReqW-1:0] {
		REQ_INSERT  = 2'd0,
		REQ_PREPEND = 2'd1,
		REQ_REMOVE  = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	// Per-request control broadcast to every cell
	typedef struct packed {
		logic ins_sorted;
		logic ins_front;
		logic remove;
	} skq_ctl_t;

endpackage

@@ rtl/core/skq_cell.sv @@
`timescale 1ns / 1ps

module skq_cell
	import skq_pkg::*;
#(
	parameter bit IS_HEAD = 1'b0
) (
	input  logic                   clk,
	input  skq_ctl_t               ctl,
	input  logic signed [KeyW-1:0] new_key,
	input  logic [TagW-1:0]        new_tag,
	input  logic                   occupied,
	input  logic signed [KeyW-1:0] left_key,
	input  logic [TagW-1:0]        left_tag,
	input  logic signed [KeyW-1:0] right_key,
	input  logic [TagW-1:0]        right_tag,
	input  logic                   found_in,
	output logic signed [KeyW-1:0] key,
	output logic [TagW-1:0]        tag,
	output logic                   found_out
);

	logic signed [KeyW-1:0] key_q;
	logic [TagW-1:0]        tag_q;
	logic                   stop;
	logic                   place;
	logic                   shift;

	// Insert point: head takes keys at most its own, others stop at a larger key
	always_comb begin
		if (IS_HEAD) begin
			stop = !occupied || (new_key <= key_q);
		end else begin
			stop = !occupied || (key_q > new_key);
		end
		found_out = found_in | stop;
		if (ctl.ins_front) begin
			place = IS_HEAD;
			shift = !IS_HEAD;
		end else begin
			place = ctl.ins_sorted && stop && !found_in;
			shift = ctl.ins_sorted && found_in;
		end
	end

	// Entry register: move toward head on remove, away on insert
	always_ff @(posedge clk) begin
		if (ctl.remove) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end else if (place) begin
			key_q <= new_key;
			tag_q <= new_tag;
		end else if (shift) begin
			key_q <= left_key;
			tag_q <= left_tag;
		end
	end

	assign key = key_q;
	assign tag = tag_q;

endmodule

@@ rtl/core/sorted_key_queue_unit.sv @@
`timescale 1ns / 1ps

// Sorted key queue: holds up to QUEUE_DEPTH (key, tag) entries in a row of
// cells, head first. Each transfer on the input stream is one request (sorted
// insert, prepend at front, remove head or none) and gives exactly one result
// transfer. Every cell compares the request key with its own entry in
// parallel, the first cell that stops the walk takes the new entry and the
// cells behind it shift one place, so a request is finished in the cycle it
// is taken: one request per clock unless a held result stalls the input, with
// a single output register between the two stream sides. The insert point is
// found by a priority chain that runs through all cells in that cycle.
module sorted_key_queue_unit
	import skq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [31:0] key_in, [63:32] data_in
	input  logic [InW-1:0]   s_axis_tdata,
	// [1:0] req_type
	input  logic [ReqW-1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [31:0] key_out, [63:32] data_out, [68:64] entry_count, [71:69] zero
	output logic [OutW-1:0]  m_axis_tdata,
	// [0] removed_valid, [1] empty_flag, [2] full_flag
	output logic [FlagW-1:0] m_axis_tuser
);

	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	logic [CntW-1:0]        count_q;
	logic                   m_valid_q;
	logic [OutW-1:0]        out_data_q;
	logic [FlagW-1:0]       out_user_q;
	logic                   accept;
	req_t                   req;
	logic signed [KeyW-1:0] key_in;
	logic [TagW-1:0]        data_in;
	logic                   is_full;
	logic                   is_empty;
	skq_ctl_t               ctl;
	logic signed [KeyW-1:0] ins_key;
	logic signed [KeyW-1:0] cell_key [QUEUE_DEPTH];
	logic [TagW-1:0]        cell_tag [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0]   found;
	logic [CntW-1:0]        count_next;
	logic signed [KeyW-1:0] res_key;
	logic [TagW-1:0]        res_tag;
	logic                   res_removed;
	logic                   res_empty;
	logic                   res_full;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign req           = req_t'(s_axis_tuser);
	assign key_in        = s_axis_tdata[KeyW-1:0];
	assign data_in       = s_axis_tdata[KeyW +: TagW];
	assign is_full       = (count_q == CntW'(QUEUE_DEPTH));
	assign is_empty      = (count_q == '0);

	// Request decode and result fields
	always_comb begin
		ctl         = '0;
		ins_key     = key_in;
		count_next  = count_q;
		res_key     = '0;
		res_tag     = '0;
		res_removed = 1'b0;
		res_empty   = 1'b0;
		res_full    = 1'b0;
		unique case (req)
			REQ_INSERT: begin
				if (is_full) begin
					res_full = 1'b1;
				end else begin
					ctl.ins_sorted = accept;
					res_key        = key_in;
					count_next     = count_q + 1'b1;
				end
			end
			REQ_PREPEND: begin
				ins_key = is_empty ? '0 : (cell_key[0] - KeyW'(1));
				if (is_full) begin
					res_full = 1'b1;
				end else begin
					ctl.ins_front = accept;
					res_key       = ins_key;
					count_next    = count_q + 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (is_empty) begin
					res_empty = 1'b1;
				end else begin
					ctl.remove  = accept;
					res_key     = cell_key[0];
					res_tag     = cell_tag[0];
					res_removed = 1'b1;
					count_next  = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Row of cells with the insert-point chain running head to tail
	assign found[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam int unsigned L = (i == 0) ? 0 : i - 1;
		localparam int unsigned R = (i == QUEUE_DEPTH - 1) ? i : i + 1;

		skq_cell #(
			.IS_HEAD(i == 0)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.new_key  (ins_key),
			.new_tag  (data_in),
			.occupied (CntW'(i) < count_q),
			.left_key (cell_key[L]),
			.left_tag (cell_tag[L]),
			.right_key(cell_key[R]),
			.right_tag(cell_tag[R]),
			.found_in (found[i]),
			.key      (cell_key[i]),
			.tag      (cell_tag[i]),
			.found_out(found[i+1])
		);
	end

	// Fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {{(OutW - CountW - TagW - KeyW){1'b0}}, CountW'(count_next),
				res_tag, res_key};
			out_user_q <= {res_full, res_empty, res_removed};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH))
		else $error("fill count beyond queue depth");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(out_user_q[0] && out_user_q[1]))
		else $error("removed and empty flagged together");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_full && (req == REQ_INSERT || req == REQ_PREPEND))
		|=> (count_q == CntW'(QUEUE_DEPTH)))
		else $error("dropped request changed the fill count");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_valid_q)
		else $error("accepted request produced no result");

endmodule
